### rtl/tvfe_pkg.sv
// Package for the tag/value field extractor: widths, byte codes, command codes
// and the structs passed between the schema table, the parser and the top level.
// No dependencies.
`default_nettype none

package tvfe_pkg;

    // Schema table geometry and digit limit
    localparam int TABLE_ENTRIES = 32;
    localparam int MAX_DIGITS    = 18;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Field widths
    localparam int INDEX_W = 5;
    localparam int ETAG_W  = 16;
    localparam int DIG_W   = 5;
    localparam int TAG_W   = 20;
    localparam int LEN_W   = 8;
    localparam int VAL_W   = 60;

    // Byte codes
    localparam logic [7:0] SEP_BYTE  = 8'h01;
    localparam logic [7:0] EQ_BYTE   = 8'h3D;
    localparam logic [7:0] ZERO_BYTE = 8'h30;
    localparam logic [7:0] MAX_DIGIT = 8'd9;

    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_ENTRY = 1'b1
    } cmd_t;

    // Schema entry write
    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] index;
        logic [ETAG_W-1:0]  tag;
        logic [DIG_W-1:0]   digits;
    } entry_wr_t;

    // Result of a tag lookup
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [DIG_W-1:0]  digits;
    } lookup_t;

    // One field result
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [TAG_W-1:0]   tag;
        logic [LEN_W-1:0]   length;
        logic               numeric;
        logic               ok;
        logic [VAL_W-1:0]   value;
    } field_t;

endpackage

`default_nettype wire

### rtl/tag_value_field_extractor_unit.sv
// Top level of the tag/value field extractor: input register, parser, schema
// table and result register. Uses tvfe_pkg, tvfe_schema_table, tvfe_field_parser.
//
// Usage:
//   Item channel (item_valid / item_ready) carries either one message byte
//   (cmd = CMD_BYTE, data_byte, end_of_message) or one schema entry write
//   (cmd = CMD_ENTRY, entry_index, entry_tag, entry_digits). Fields are
//   "tag=value" ended by byte 0x01; end_of_message also closes a field after its '=', and drops a tag without one.
//   Result channel (result_valid / result_ready) carries one field result per
//   closed field: match, slot, tag, value length and the decimal value of the
//   first D value bytes for numeric schema entries.
//   Path: an accepted item is held in the input register; its result, if any,
//   loads into the result register when the item advances, which sets
//   result_valid. Throughput: one item per cycle while the result side keeps
//   up, set by the parser step (tag multiply-add, parallel 32-slot tag compare,
//   value multiply-add) between the two registers.
//   Stall: while a result waits, the input register still moves if the result
//   register is being drained; otherwise the input register holds and item_ready
//   drops once it is full. Nothing is lost or repeated.
//   Reset: parser restarts in tag scan, all schema slots become invalid, both
//   registers empty. Slots are filled only by entry writes.
`default_nettype none

module tag_value_field_extractor_unit
    import tvfe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic               cmd,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_of_message,
    input  wire logic [INDEX_W-1:0] entry_index,
    input  wire logic [ETAG_W-1:0]  entry_tag,
    input  wire logic [DIG_W-1:0]   entry_digits,

    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic                    field_found,
    output logic [INDEX_W-1:0]      field_index,
    output logic [TAG_W-1:0]        tag_number,
    output logic [LEN_W-1:0]        value_length,
    output logic                    is_numeric,
    output logic                    value_ok,
    output logic [VAL_W-1:0]        numeric_value
);

    // Input register
    logic               item_valid_reg;
    cmd_t               cmd_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [ETAG_W-1:0]  etag_reg;
    logic [DIG_W-1:0]   digits_reg;

    // Result register
    logic   result_valid_reg;
    field_t result_reg;

    logic       advance;
    logic       byte_step;
    entry_wr_t  entry_wr;
    lookup_t    lookup;
    logic [TAG_W-1:0] tag_key;
    logic       emit;
    field_t     field;

    // Advance the held item when the result register is free or draining
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;
    assign byte_step  = advance && (cmd_reg == CMD_BYTE);

    always_comb
    begin
        entry_wr        = '0;
        entry_wr.en     = advance && (cmd_reg == CMD_ENTRY);
        entry_wr.index  = index_reg;
        entry_wr.tag    = etag_reg;
        entry_wr.digits = digits_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    // Payload holds until the next accept
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            cmd_reg    <= cmd_t'(cmd);
            byte_reg   <= data_byte;
            last_reg   <= end_of_message;
            index_reg  <= entry_index;
            etag_reg   <= entry_tag;
            digits_reg <= entry_digits;
        end
    end

    tvfe_schema_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (entry_wr),
        .tag_key (tag_key),
        .lookup  (lookup)
    );

    tvfe_field_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (byte_step),
        .data_byte (byte_reg),
        .last      (last_reg),
        .lookup    (lookup),
        .tag_key   (tag_key),
        .emit      (emit),
        .field     (field)
    );

    // Load a new result on emit, otherwise drop the old one once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (byte_step && emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_step && emit)
        begin
            result_reg <= field;
        end
    end

    assign result_valid  = result_valid_reg;
    assign field_found   = result_reg.found;
    assign field_index   = result_reg.index;
    assign tag_number    = result_reg.tag;
    assign value_length  = result_reg.length;
    assign is_numeric    = result_reg.numeric;
    assign value_ok      = result_reg.ok;
    assign numeric_value = result_reg.value;

`ifndef SYNTHESIS
    a_value_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !value_ok) |-> (numeric_value == '0))
        else $error("numeric_value nonzero on a field without a valid value");

    a_ok_needs_numeric: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (value_ok || is_numeric)) |-> (is_numeric && field_found))
        else $error("value_ok or is_numeric on a field that is not a numeric match");

    a_index_zero_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !field_found) |-> (field_index == '0))
        else $error("field_index nonzero without a match");

    a_entry_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd_reg == CMD_ENTRY) && !result_valid) |=> !result_valid)
        else $error("schema entry write produced a result");
`endif

endmodule

`default_nettype wire

### rtl/tvfe_schema_table.sv
// Schema table: per-slot tag and digit count registers with valid bits, and a
// parallel priority lookup of the lowest valid slot matching a tag. Uses tvfe_pkg.
`default_nettype none

module tvfe_schema_table
    import tvfe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire entry_wr_t        wr,
    input  wire logic [TAG_W-1:0] tag_key,
    output lookup_t               lookup
);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [ETAG_W-1:0]        tags_reg   [TABLE_ENTRIES];
    logic [DIG_W-1:0]         digits_reg [TABLE_ENTRIES];

    logic              wr_ok;
    logic [SLOT_W-1:0] wr_slot;
    logic [DIG_W-1:0]  wr_digits;

    // Drop writes beyond the table; clamp the digit count
    assign wr_ok     = wr.en && (int'(wr.index) < TABLE_ENTRIES);
    assign wr_slot   = SLOT_W'(wr.index);
    assign wr_digits = (int'(wr.digits) > MAX_DIGITS) ? DIG_W'(MAX_DIGITS) : wr.digits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_ok)
        begin
            valid_reg[wr_slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            tags_reg[wr_slot]   <= wr.tag;
            digits_reg[wr_slot] <= wr_digits;
        end
    end

    // Scan from the top so the lowest matching slot wins
    always_comb
    begin
        lookup = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (TAG_W'(tags_reg[i]) == tag_key))
            begin
                lookup.hit    = 1'b1;
                lookup.slot   = SLOT_W'(i);
                lookup.digits = digits_reg[i];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/tvfe_field_parser.sv
// Field parser: tag accumulation, lookup latch at '=', value counting and decimal
// conversion, and the field result for one message byte. Uses tvfe_pkg.
`default_nettype none

module tvfe_field_parser
    import tvfe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last,
    input  wire lookup_t          lookup,
    output logic [TAG_W-1:0]      tag_key,
    output logic                  emit,
    output field_t                field
);

    logic              in_value_reg, in_value_next;
    logic [TAG_W-1:0]  tag_acc_reg,  tag_acc_next;
    logic [LEN_W-1:0]  count_reg,    count_next;
    logic [VAL_W-1:0]  val_acc_reg,  val_acc_next;
    logic              good_reg,     good_next;
    logic              hit_reg,      hit_next;
    logic [SLOT_W-1:0] slot_reg,     slot_next;
    logic [DIG_W-1:0]  fdig_reg,     fdig_next;
    logic [DIG_W-1:0]  dpos_reg,     dpos_next;

    logic [7:0] digit;
    logic       restart;
    logic       numeric;
    logic       ok;

    assign tag_key = tag_acc_reg;
    assign digit   = data_byte - ZERO_BYTE;

    always_comb
    begin
        in_value_next = in_value_reg;
        tag_acc_next  = tag_acc_reg;
        count_next    = count_reg;
        val_acc_next  = val_acc_reg;
        good_next     = good_reg;
        hit_next      = hit_reg;
        slot_next     = slot_reg;
        fdig_next     = fdig_reg;
        dpos_next     = dpos_reg;
        emit          = 1'b0;
        restart       = 1'b0;

        if (!in_value_reg)
        begin
            if (data_byte == EQ_BYTE)
            begin
                // Latch the match and its digit count
                in_value_next = 1'b1;
                hit_next      = lookup.hit;
                slot_next     = lookup.slot;
                fdig_next     = lookup.hit ? lookup.digits : '0;
                emit          = last;
            end
            else
            begin
                // tag * 10 + (byte - '0'), modulo 2^20
                tag_acc_next = TAG_W'((tag_acc_reg << 3) + (tag_acc_reg << 1)
                                      + TAG_W'(data_byte) - TAG_W'(ZERO_BYTE));
                restart      = last;
            end
        end
        else
        begin
            if (data_byte != SEP_BYTE)
            begin
                count_next = count_reg + LEN_W'(1);
                if (dpos_reg < fdig_reg)
                begin
                    if (digit > MAX_DIGIT)
                    begin
                        good_next = 1'b0;
                    end
                    else if (good_reg)
                    begin
                        val_acc_next = VAL_W'((val_acc_reg << 3) + (val_acc_reg << 1)
                                              + VAL_W'(digit));
                    end
                    dpos_next = dpos_reg + DIG_W'(1);
                end
            end
            emit = (data_byte == SEP_BYTE) || last;
        end
    end

    assign numeric = hit_next && (fdig_next != '0);
    assign ok      = numeric && good_next && (dpos_next >= fdig_next);

    always_comb
    begin
        field         = '0;
        field.found   = hit_next;
        field.index   = hit_next ? INDEX_W'(slot_next) : '0;
        field.tag     = tag_acc_next;
        field.length  = count_next;
        field.numeric = numeric;
        field.ok      = ok;
        field.value   = ok ? val_acc_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_value_reg <= 1'b0;
            tag_acc_reg  <= '0;
            count_reg    <= '0;
            val_acc_reg  <= '0;
            good_reg     <= 1'b1;
            hit_reg      <= 1'b0;
            slot_reg     <= '0;
            fdig_reg     <= '0;
            dpos_reg     <= '0;
        end
        else if (step)
        begin
            if (restart || emit)
            begin
                in_value_reg <= 1'b0;
                tag_acc_reg  <= '0;
                count_reg    <= '0;
                val_acc_reg  <= '0;
                good_reg     <= 1'b1;
                hit_reg      <= 1'b0;
                slot_reg     <= '0;
                fdig_reg     <= '0;
                dpos_reg     <= '0;
            end
            else
            begin
                in_value_reg <= in_value_next;
                tag_acc_reg  <= tag_acc_next;
                count_reg    <= count_next;
                val_acc_reg  <= val_acc_next;
                good_reg     <= good_next;
                hit_reg      <= hit_next;
                slot_reg     <= slot_next;
                fdig_reg     <= fdig_next;
                dpos_reg     <= dpos_next;
            end
        end
    end

endmodule

`default_nettype wire

### dv/tag_value_field_extractor_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for tag_value_field_extractor_unit: directed and random
// tag=value message streams with schema writes, scored against a built-in parser model.
// Depends on tvfe_pkg and the extractor RTL only.

module tag_value_field_extractor_unit_test;
    import tvfe_pkg::*;

    // Cycles to wait after the last expected field so a stray result can still show up
    localparam int SETTLE_CYCLES = 8;

    // One item on the input channel, either a message byte or a schema write
    typedef struct {
        cmd_t               op;
        logic [7:0]         data;
        logic               eom;
        logic [INDEX_W-1:0] slot;
        logic [ETAG_W-1:0]  tag;
        logic [DIG_W-1:0]   digits;
    } item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               item_valid = 1'b0;
    logic               item_ready;
    logic               cmd = CMD_BYTE;
    logic [7:0]         data_byte = '0;
    logic               end_of_message = 1'b0;
    logic [INDEX_W-1:0] entry_index = '0;
    logic [ETAG_W-1:0]  entry_tag = '0;
    logic [DIG_W-1:0]   entry_digits = '0;

    logic               result_valid;
    logic               result_ready = 1'b0;
    logic               field_found;
    logic [INDEX_W-1:0] field_index;
    logic [TAG_W-1:0]   tag_number;
    logic [LEN_W-1:0]   value_length;
    logic               is_numeric;
    logic               value_ok;
    logic [VAL_W-1:0]   numeric_value;

    // Idle limits, changed per test to vary the pressure on both channels
    int                 send_gap_max = 0;
    int                 sink_stall_max = 0;

    int unsigned        items_sent = 0;
    int unsigned        mismatch_count = 0;

    // Fields the parser model says must come out, oldest first
    field_t             pending_fields[$];
    // Message under construction, sent as a whole by send_message
    item_t              msg_items[$];

    // Parser model: schema copy and the state of the field being scanned
    logic [ETAG_W-1:0]  slot_tag[TABLE_ENTRIES];
    logic [DIG_W-1:0]   slot_digits[TABLE_ENTRIES];
    bit                 slot_valid[TABLE_ENTRIES] = '{default: 1'b0};
    bit                 scanning_value = 1'b0;
    logic [TAG_W-1:0]   tag_sum = '0;
    logic [LEN_W-1:0]   value_bytes = '0;
    logic [VAL_W-1:0]   value_sum = '0;
    bit                 digits_clean = 1'b1;
    int                 field_slot = -1;
    int                 want_digits = 0;
    int                 digit_seen = 0;

    tag_value_field_extractor_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .cmd            (cmd),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .entry_index    (entry_index),
        .entry_tag      (entry_tag),
        .entry_digits   (entry_digits),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .field_found    (field_found),
        .field_index    (field_index),
        .tag_number     (tag_number),
        .value_length   (value_length),
        .is_numeric     (is_numeric),
        .value_ok       (value_ok),
        .numeric_value  (numeric_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    // Lowest valid slot holding this tag, -1 when none does
    function automatic int first_slot(logic [TAG_W-1:0] t);
        int hit;
        hit = -1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (slot_valid[i] && TAG_W'(slot_tag[i]) == t)
                hit = i;
        end
        return hit;
    endfunction

    // Drop back to tag scan with a clean field
    function automatic void restart_field();
        scanning_value = 1'b0;
        tag_sum        = '0;
        value_bytes    = '0;
        value_sum      = '0;
        digits_clean   = 1'b1;
        field_slot     = -1;
        want_digits    = 0;
        digit_seen     = 0;
    endfunction

    // Queue the field that just closed, then restart the scan
    function automatic void close_field();
        field_t f;
        f.found   = (field_slot >= 0);
        f.index   = f.found ? INDEX_W'(field_slot) : '0;
        f.tag     = tag_sum;
        f.length  = value_bytes;
        f.numeric = f.found && want_digits != 0;
        f.ok      = f.numeric && digits_clean && digit_seen >= want_digits;
        f.value   = f.ok ? value_sum : '0;
        pending_fields.push_back(f);
        restart_field();
    endfunction

    // Advance the model by one accepted item
    function automatic void parse_step(item_t it);
        logic [7:0] d;
        if (it.op == CMD_ENTRY)
        begin
            // Digit counts above the limit are stored saturated
            slot_tag[it.slot]    = it.tag;
            slot_digits[it.slot] = (it.digits > DIG_W'(MAX_DIGITS)) ? DIG_W'(MAX_DIGITS)
                                                                     : it.digits;
            slot_valid[it.slot]  = 1'b1;
        end
        else if (!scanning_value)
        begin
            if (it.data == EQ_BYTE)
            begin
                // Match and digit count are frozen here for the whole value
                field_slot     = first_slot(tag_sum);
                want_digits    = (field_slot >= 0) ? int'(slot_digits[field_slot]) : 0;
                scanning_value = 1'b1;
                if (it.eom)
                    close_field();
            end
            else
            begin
                // Every tag byte folds in, digit or not, modulo 2^TAG_W
                tag_sum = tag_sum * TAG_W'(10) + TAG_W'(it.data) - TAG_W'(ZERO_BYTE);
                if (it.eom)
                    restart_field();
            end
        end
        else
        begin
            if (it.data != SEP_BYTE)
            begin
                value_bytes++;
                if (digit_seen < want_digits)
                begin
                    d = it.data - ZERO_BYTE;
                    if (d > MAX_DIGIT)
                        digits_clean = 1'b0;
                    else if (digits_clean)
                        value_sum = value_sum * VAL_W'(10) + VAL_W'(d);
                    digit_seen++;
                end
            end
            if (it.data == SEP_BYTE || it.eom)
                close_field();
        end
    endfunction

    // ------------------------------------------------------------------
    // Message building
    // ------------------------------------------------------------------

    // Append a message byte; the unused entry fields carry random noise
    function automatic void push_byte(logic [7:0] b);
        item_t it;
        it.op     = CMD_BYTE;
        it.data   = b;
        it.eom    = 1'b0;
        it.slot   = INDEX_W'($urandom);
        it.tag    = ETAG_W'($urandom);
        it.digits = DIG_W'($urandom);
        msg_items.push_back(it);
    endfunction

    // Append a schema write; the unused byte fields carry random noise
    function automatic void push_entry(int s, int t, int d);
        item_t it;
        it.op     = CMD_ENTRY;
        it.data   = 8'($urandom);
        it.eom    = 1'($urandom);
        it.slot   = INDEX_W'(s);
        it.tag    = ETAG_W'(t);
        it.digits = DIG_W'(d);
        msg_items.push_back(it);
    endfunction

    // Small tags now and then so duplicate slots show up
    function automatic void push_random_entry();
        push_entry($urandom_range(0, TABLE_ENTRIES - 1),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 65535),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_DIGITS + 1, 31)
                                               : $urandom_range(0, MAX_DIGITS));
    endfunction

    function automatic void push_text(string s);
        foreach (s[i])
            push_byte(s[i]);
    endfunction

    function automatic void push_digits(int unsigned v);
        logic [7:0] txt[$];
        do
        begin
            txt.push_front(8'(ZERO_BYTE + v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (txt[i])
            push_byte(txt[i]);
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'(ZERO_BYTE + $urandom_range(0, 9));
    endfunction

    function automatic void push_digit_run(int n);
        repeat (n)
            push_byte(random_digit());
    endfunction

    function automatic logic [7:0] random_non_digit();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while ((b >= ZERO_BYTE && b <= ZERO_BYTE + MAX_DIGIT) || b == SEP_BYTE);
        return b;
    endfunction

    // Any byte that stays inside a value; a stray separator turns into a second '='
    function automatic logic [7:0] random_value_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == SEP_BYTE) ? EQ_BYTE : b;
    endfunction

    // Append one tag=value field; the last field of a message may leave out its separator
    function automatic void build_field(bit last);
        int         pick;
        int         slot;
        int         fill;
        int         digits;
        int         spot;
        logic [7:0] b;
        pick   = $urandom_range(0, 9);
        slot   = $urandom_range(0, TABLE_ENTRIES - 1);
        digits = $urandom_range(0, MAX_DIGITS);
        for (int i = 0; i < TABLE_ENTRIES && !slot_valid[slot]; i++)
            slot = (slot + 1) % TABLE_ENTRIES;

        // Tag: mostly one the schema knows, else a wide number or raw bytes
        if (pick < 7 && slot_valid[slot])
        begin
            if ($urandom_range(0, 7) == 0)
                push_byte(ZERO_BYTE);
            push_digits(slot_tag[slot]);
            digits = slot_digits[slot];
        end
        else if (pick < 9)
        begin
            push_digits($urandom);
        end
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                b = 8'($urandom);
                push_byte((b == EQ_BYTE) ? SEP_BYTE : b);
            end
        end
        push_byte(EQ_BYTE);

        // Value: mostly the expected digit count, else short, broken, padded or raw
        fill = $urandom_range(0, 9);
        if (digits == 0 || fill == 9)
        begin
            repeat ($urandom_range(0, 10))
                push_byte(random_value_byte());
        end
        else if (fill == 6)
        begin
            push_digit_run($urandom_range(0, digits - 1));
        end
        else if (fill == 7)
        begin
            spot = $urandom_range(0, digits - 1);
            for (int i = 0; i < digits; i++)
                push_byte((i == spot) ? random_non_digit() : random_digit());
        end
        else
        begin
            push_digit_run(digits);
            if (fill == 8)
            begin
                repeat ($urandom_range(1, 5))
                    push_byte(random_value_byte());
            end
        end

        if (!last || $urandom_range(0, 1) == 1)
            push_byte(SEP_BYTE);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers and result checking
    // ------------------------------------------------------------------

    // Send one item: idle for a random gap, then hold valid and payload until taken.
    // Valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_item(item_t it);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd            <= it.op;
        data_byte      <= it.data;
        end_of_message <= it.eom;
        entry_index    <= it.slot;
        entry_tag      <= it.tag;
        entry_digits   <= it.digits;
        item_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        parse_step(it);
        items_sent++;
    endtask

    // Send the built message, marking its last byte as the end when asked
    task automatic send_message(bit mark_end);
        item_t tail;
        if (mark_end && msg_items[$].op == CMD_BYTE)
        begin
            tail     = msg_items.pop_back();
            tail.eom = 1'b1;
            msg_items.push_back(tail);
        end
        foreach (msg_items[i])
            send_item(msg_items[i]);
        msg_items.delete();
    endtask

    // Drop valid and hold off until every expected field has come out
    task automatic hold_until_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_fields.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: stall a random number of cycles before taking each field
    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, sink_stall_max);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_valid && result_ready));
        end
    end

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Score every accepted field against the oldest expectation
    always @(posedge clk)
    begin
        field_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_fields.size() == 0)
            begin
                $error("field result with none expected, tag_number %0d", tag_number);
                mismatch_count++;
            end
            else
            begin
                want = pending_fields.pop_front();
                compare_field("field_found", want.found, field_found);
                compare_field("field_index", want.index, field_index);
                compare_field("tag_number", want.tag, tag_number);
                compare_field("value_length", want.length, value_length);
                compare_field("is_numeric", want.numeric, is_numeric);
                compare_field("value_ok", want.ok, value_ok);
                compare_field("numeric_value", want.value, numeric_value);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty schema: nothing matches, message end inside a tag gives no field,
    // and an end marked on '=' gives an empty field with tag 0
    task automatic test_empty_schema();
        send_gap_max   = 2;
        sink_stall_max = 2;
        push_text("35=7");
        push_byte(SEP_BYTE);
        send_message(1'b0);
        push_text("12");
        send_message(1'b1);
        push_text("=");
        send_message(1'b1);
    endtask

    // Slot and tag extremes, a saturated digit count, a duplicate tag in a
    // higher slot and a match on tag 0
    task automatic test_schema_extremes();
        push_entry(0, 35, 4);
        push_entry(TABLE_ENTRIES - 1, 65535, 31);
        push_entry(5, 35, 2);
        push_entry(1, 0, 0);
        send_message(1'b0);
        push_text("=x");
        send_message(1'b1);
        push_text("65535=12");
        push_byte(SEP_BYTE);
        send_message(1'b1);
    endtask

    // Value cases: exact, longer and shorter than D, a non-digit, end marked on
    // a value byte, the widest value, separator inside a tag, second '=' in a
    // value, and schema writes both before and after '='
    task automatic test_field_cases();
        push_text("35=1234");
        push_byte(SEP_BYTE);
        push_text("35=123456");
        push_byte(SEP_BYTE);
        push_text("35=12");
        push_byte(SEP_BYTE);
        push_text("35=1a34");
        send_message(1'b1);

        push_text("65535=999999999999999999");
        push_byte(SEP_BYTE);
        push_text("35=0000");
        push_byte(SEP_BYTE);
        send_message(1'b1);

        push_byte(SEP_BYTE);
        push_text("=a=b");
        push_byte(SEP_BYTE);
        send_message(1'b1);

        push_text("7");
        push_entry(2, 7, 1);
        push_text("=5");
        push_entry(2, 7, 0);
        push_text("9");
        push_byte(SEP_BYTE);
        send_message(1'b1);
    endtask

    // One value past 256 bytes: the length wraps, the digit window stays closed
    task automatic test_length_wrap();
        push_text("35=");
        push_digit_run(4);
        repeat (296)
            push_byte(random_value_byte());
        push_byte(SEP_BYTE);
        send_message(1'b1);
    endtask

    // Random messages until count more items have gone in: mostly well-formed
    // fields, some schema writes (also inside messages) and some broken noise
    task automatic run_random_traffic(int gap_max, int stall_max, int unsigned count);
        int unsigned goal;
        int          r;
        int          fields;
        item_t       wr;
        goal           = items_sent + count;
        send_gap_max   = gap_max;
        sink_stall_max = stall_max;
        while (items_sent < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                push_random_entry();
                send_message(1'b0);
            end
            else if (r < 12)
            begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom));
                send_message($urandom_range(0, 1));
            end
            else
            begin
                fields = $urandom_range(1, 4);
                for (int i = 0; i < fields; i++)
                    build_field(i == fields - 1);
                if (r < 18)
                begin
                    push_random_entry();
                    wr = msg_items.pop_back();
                    msg_items.insert($urandom_range(0, msg_items.size() - 1), wr);
                end
                send_message(1'b1);
            end
        end
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        run_random_traffic(0, 0, 100);
    endtask

    // Heavy idling both ways, a full drain, then one-sided pressure
    task automatic test_random_traffic();
        run_random_traffic(16, 16, 150);
        hold_until_drained();
        run_random_traffic(0, 8, 150);
        run_random_traffic(4, 0, 100);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Hold reset low, then release it on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_schema();
        test_schema_extremes();
        test_field_cases();
        test_length_wrap();
        test_back_to_back();
        test_random_traffic();

        hold_until_drained();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
